FILE: design/ftrm_pkg.sv
// Shared constants and widths for the fan tachometer with median filter.
package ftrm_pkg;

	localparam int FAN_COUNT   = 2;
	localparam int FAN_W       = $clog2(FAN_COUNT);
	localparam int COUNT_W     = 16;
	localparam int SPEED_W     = 17;
	localparam int PPR_W       = 4;
	localparam int PRODUCT_W   = 32;
	localparam int DIVISOR_W   = 20;
	localparam int DIV_CNT_W   = $clog2(PRODUCT_W);
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 17;

	localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;
	localparam logic [COUNT_W-1:0] MS_PER_MINUTE = 16'd60000;

	localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_REV = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RPM        = 2'd2;

	localparam logic [COUNT_W-1:0]  RST_UPDATE_PERIOD  = 16'd1000;
	localparam logic [PPR_W-1:0]    RST_PULSES_PER_REV = 4'd2;
	localparam logic [SPEED_W-1:0]  RST_MAX_RPM        = 17'd10000;

endpackage

FILE: design/ftrm_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module ftrm_div
	import ftrm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [PRODUCT_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic                 done,
	output logic [PRODUCT_W-1:0] quotient
);

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [PRODUCT_W-1:0] dvd_q;
	logic [DIVISOR_W-1:0] rem_q;

	logic [DIVISOR_W:0]   rem_sh;
	logic                 fits;
	logic [DIVISOR_W:0]   rem_nxt;

	// shift the next dividend bit in, subtract when the divisor fits
	assign rem_sh  = {rem_q, dvd_q[PRODUCT_W-1]};
	assign fits    = rem_sh >= {1'b0, divisor};
	assign rem_nxt = fits ? (rem_sh - {1'b0, divisor}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				dvd_q <= dividend;
				rem_q <= '0;
			end else if (run_q) begin
				// quotient bits fill the dividend register from the bottom
				dvd_q <= {dvd_q[PRODUCT_W-2:0], fits};
				rem_q <= rem_nxt[DIVISOR_W-1:0];
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(PRODUCT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

FILE: design/fan_tacho_rpm_median.sv
// Two-fan tachometer: edge counting, rpm division and running median filter.
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_stall    edge_fan0, edge_fan1, ms_tick
//  out       source     out_valid / out_stall  speed_fan0, speed_fan1, spike_fan0, spike_fan1
//  cfg       sink       cfg_we                 cfg_index, cfg_data
//
// An input beat that does not close the update period only updates the counters.
// A beat that closes the period starts an update: per fan a multiply step,
// the shared divider, a check step, a rank-select median over the n filled
// window entries through the single window memory read port and a step to
// move on to the next fan; a spike skips the median.
// in_stall stays high for the whole update; the result beat then waits in the
// output register, and input beats are taken again while out_stall holds it.
// Reset restores the register defaults and clears counters, fill and speeds.
module fan_tacho_rpm_median
	import ftrm_pkg::*;
#(
	parameter int WINDOW_SIZE = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  edge_fan0,
	input  logic                  edge_fan1,
	input  logic                  ms_tick,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [SPEED_W-1:0]    speed_fan0,
	output logic [SPEED_W-1:0]    speed_fan1,
	output logic                  spike_fan0,
	output logic                  spike_fan1,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W     = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int CNT_W     = $clog2(WINDOW_SIZE + 1);
	localparam int MEM_DEPTH = FAN_COUNT * WINDOW_SIZE;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_CHECK,
		ST_CAND_RD,
		ST_CAND_CAP,
		ST_CMP_RD,
		ST_CMP_DO,
		ST_RANK,
		ST_AVG,
		ST_NEXT_FAN,
		ST_HOLD
	} state_t;

	state_t state_q;

	// configuration
	logic [COUNT_W-1:0] period_q;
	logic [PPR_W-1:0]   ppr_q;
	logic [SPEED_W-1:0] max_rpm_q;

	// counting
	logic [COUNT_W-1:0] cnt_q [FAN_COUNT];
	logic [COUNT_W-1:0] upd_cnt_q [FAN_COUNT];
	logic [COUNT_W-1:0] elapsed_q;

	// filter state
	logic [CNT_W-1:0]   fill_q [FAN_COUNT];
	logic [IDX_W-1:0]   wpos_q [FAN_COUNT];
	logic [SPEED_W-1:0] held_q [FAN_COUNT];
	logic               spike_q [FAN_COUNT];

	// update datapath
	logic [FAN_W-1:0]     fan_q;
	logic [PRODUCT_W-1:0] prod_q;
	logic [DIVISOR_W-1:0] dvsr_q;
	logic [PRODUCT_W-1:0] raw_q;
	logic [CNT_W-1:0]     n_q;
	logic [IDX_W-1:0]     i_q;
	logic [IDX_W-1:0]     j_q;
	logic [SPEED_W-1:0]   cand_q;
	logic [CNT_W-1:0]     lt_q;
	logic [CNT_W-1:0]     le_q;
	logic [SPEED_W-1:0]   lo_q;
	logic [SPEED_W-1:0]   hi_q;

	// output register
	logic               out_valid_q;
	logic [SPEED_W-1:0] out_speed_q [FAN_COUNT];
	logic               out_spike_q [FAN_COUNT];

	// window memory
	logic [SPEED_W-1:0] mem_q [MEM_DEPTH];
	logic [SPEED_W-1:0] rd_data_q;
	logic [MEM_AW-1:0]  fan_base;
	logic [MEM_AW-1:0]  mem_waddr;
	logic [MEM_AW-1:0]  mem_raddr;
	logic               mem_we;

	logic               in_acc;
	logic [COUNT_W-1:0] cnt_nxt [FAN_COUNT];
	logic [COUNT_W-1:0] elapsed_nxt;
	logic [COUNT_W-1:0] period_eff;
	logic [PPR_W-1:0]   ppr_eff;
	logic               period_hit;
	logic               spike_now;
	logic [CNT_W-1:0]   n_new;
	logic [CNT_W-1:0]   k_lo;
	logic [CNT_W-1:0]   k_hi;
	logic               j_last;
	logic               i_last;
	logic [SPEED_W:0]   mid_sum;
	logic               out_load;
	logic               div_start;
	logic               div_done;
	logic [PRODUCT_W-1:0] div_quot;

	// zero period or zero pulses per revolution act as one
	assign period_eff = (period_q == '0) ? COUNT_W'(1) : period_q;
	assign ppr_eff    = (ppr_q == '0) ? PPR_W'(1) : ppr_q;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// count this beat's edges and tick before the period check
	assign cnt_nxt[0] = (edge_fan0 && cnt_q[0] != COUNT_MAX) ? cnt_q[0] + 1'b1 : cnt_q[0];
	assign cnt_nxt[1] = (edge_fan1 && cnt_q[1] != COUNT_MAX) ? cnt_q[1] + 1'b1 : cnt_q[1];
	assign elapsed_nxt = (ms_tick && elapsed_q != COUNT_MAX) ? elapsed_q + 1'b1 : elapsed_q;
	assign period_hit  = elapsed_nxt >= period_eff;

	assign spike_now = raw_q > PRODUCT_W'(max_rpm_q);
	assign n_new     = (fill_q[fan_q] < CNT_W'(WINDOW_SIZE)) ? fill_q[fan_q] + 1'b1 : fill_q[fan_q];

	// ranks of the two middle values; equal for an odd count
	assign k_lo   = (n_q - 1'b1) >> 1;
	assign k_hi   = n_q >> 1;
	assign j_last = (CNT_W'(j_q) == n_q - 1'b1);
	assign i_last = (CNT_W'(i_q) == n_q - 1'b1);
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};

	assign fan_base  = (fan_q != '0) ? MEM_AW'(WINDOW_SIZE) : '0;
	assign mem_waddr = fan_base + MEM_AW'(wpos_q[fan_q]);
	assign mem_raddr = fan_base + MEM_AW'((state_q == ST_CAND_RD) ? i_q : j_q);
	assign mem_we    = (state_q == ST_CHECK) && !spike_now;

	assign div_start = (state_q == ST_DIV_GO);
	assign out_load  = (state_q == ST_HOLD) && (!out_valid_q || !out_stall);

	ftrm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (dvsr_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// window memory: one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= raw_q[SPEED_W-1:0];
		end
		rd_data_q <= mem_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			period_q    <= RST_UPDATE_PERIOD;
			ppr_q       <= RST_PULSES_PER_REV;
			max_rpm_q   <= RST_MAX_RPM;
			elapsed_q   <= '0;
			fan_q       <= '0;
			out_valid_q <= 1'b0;
			prod_q      <= '0;
			dvsr_q      <= '0;
			raw_q       <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			cand_q      <= '0;
			lt_q        <= '0;
			le_q        <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			for (int f = 0; f < FAN_COUNT; f++) begin
				cnt_q[f]       <= '0;
				upd_cnt_q[f]   <= '0;
				fill_q[f]      <= '0;
				wpos_q[f]      <= '0;
				held_q[f]      <= '0;
				spike_q[f]     <= 1'b0;
				out_speed_q[f] <= '0;
				out_spike_q[f] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_UPDATE_PERIOD:  period_q  <= cfg_data[COUNT_W-1:0];
					CFG_PULSES_PER_REV: ppr_q     <= cfg_data[PPR_W-1:0];
					CFG_MAX_RPM:        max_rpm_q <= cfg_data[SPEED_W-1:0];
					default: ;
				endcase
			end

			// load the result beat from the hold state, drop it once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
				for (int f = 0; f < FAN_COUNT; f++) begin
					out_speed_q[f] <= held_q[f];
					out_spike_q[f] <= spike_q[f];
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (period_hit) begin
							// latch the closing counts, clear for the next period
							for (int f = 0; f < FAN_COUNT; f++) begin
								upd_cnt_q[f] <= cnt_nxt[f];
								cnt_q[f]     <= '0;
								spike_q[f]   <= 1'b0;
							end
							elapsed_q <= '0;
							fan_q     <= '0;
							state_q   <= ST_MUL;
						end else begin
							cnt_q[0]  <= cnt_nxt[0];
							cnt_q[1]  <= cnt_nxt[1];
							elapsed_q <= elapsed_nxt;
						end
					end
				end
				ST_MUL: begin
					// floor(floor(x/p)/q) equals floor(x/(p*q))
					prod_q  <= PRODUCT_W'(upd_cnt_q[fan_q]) * PRODUCT_W'(MS_PER_MINUTE);
					dvsr_q  <= DIVISOR_W'(period_eff) * DIVISOR_W'(ppr_eff);
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						raw_q   <= div_quot;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (spike_now) begin
						spike_q[fan_q] <= 1'b1;
						state_q        <= ST_NEXT_FAN;
					end else begin
						// sample goes in this cycle, advance write position and fill
						wpos_q[fan_q] <= (wpos_q[fan_q] == IDX_W'(WINDOW_SIZE - 1)) ?
							'0 : wpos_q[fan_q] + 1'b1;
						fill_q[fan_q] <= n_new;
						n_q     <= n_new;
						i_q     <= '0;
						state_q <= ST_CAND_RD;
					end
				end
				ST_CAND_RD: begin
					state_q <= ST_CAND_CAP;
				end
				ST_CAND_CAP: begin
					cand_q  <= rd_data_q;
					j_q     <= '0;
					lt_q    <= '0;
					le_q    <= '0;
					state_q <= ST_CMP_RD;
				end
				ST_CMP_RD: begin
					state_q <= ST_CMP_DO;
				end
				ST_CMP_DO: begin
					// one compare per pass: rank the candidate against entry j
					if (rd_data_q < cand_q) begin
						lt_q <= lt_q + 1'b1;
					end
					if (rd_data_q <= cand_q) begin
						le_q <= le_q + 1'b1;
					end
					if (j_last) begin
						state_q <= ST_RANK;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_CMP_RD;
					end
				end
				ST_RANK: begin
					// candidate occupies sorted ranks lt .. le-1
					if (lt_q <= k_lo && k_lo < le_q) begin
						lo_q <= cand_q;
					end
					if (lt_q <= k_hi && k_hi < le_q) begin
						hi_q <= cand_q;
					end
					if (i_last) begin
						state_q <= ST_AVG;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_CAND_RD;
					end
				end
				ST_AVG: begin
					held_q[fan_q] <= mid_sum[SPEED_W:1];
					state_q       <= ST_NEXT_FAN;
				end
				ST_NEXT_FAN: begin
					if (fan_q == FAN_W'(FAN_COUNT - 1)) begin
						state_q <= ST_HOLD;
					end else begin
						fan_q   <= fan_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_HOLD: begin
					// hold until the output register is free
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign speed_fan0 = out_speed_q[0];
	assign speed_fan1 = out_speed_q[1];
	assign spike_fan0 = out_spike_q[0];
	assign spike_fan1 = out_spike_q[1];

`ifndef SYNTHESIS
	a_update_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && period_hit) |=> in_stall)
		else $error("update beat did not stall the input");

	a_div_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_WAIT))
		else $error("divider finished outside its wait state");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q[0] <= CNT_W'(WINDOW_SIZE)) && (fill_q[1] <= CNT_W'(WINDOW_SIZE)))
		else $error("window fill beyond window size");

	a_rank_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RANK) |-> (lt_q <= le_q && le_q >= CNT_W'(1)))
		else $error("candidate rank counts inconsistent");
`endif

endmodule

FILE: tb/sv/fan_tacho_rpm_median_check.sv
// Checker for the fan tachometer: predicts rpm reports from accepted beats and compares them.
`timescale 1ns / 1ps
module fan_tacho_rpm_median_check
	import ftrm_pkg::*;
#(
	parameter int WINDOW_SIZE = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  edge_fan0,
	input  logic                  edge_fan1,
	input  logic                  ms_tick,

	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [SPEED_W-1:0]    speed_fan0,
	input  logic [SPEED_W-1:0]    speed_fan1,
	input  logic                  spike_fan0,
	input  logic                  spike_fan1,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	output int                    mismatches,
	output int                    pending
);

	typedef struct packed {
		logic [SPEED_W-1:0] speed0;
		logic [SPEED_W-1:0] speed1;
		logic               spike0;
		logic               spike1;
	} rpm_report_t;

	rpm_report_t        reports_due[$];
	rpm_report_t        oldest;

	logic [COUNT_W-1:0] period_ms;
	logic [PPR_W-1:0]   pulses_per_rev;
	logic [SPEED_W-1:0] rpm_ceiling;

	logic [COUNT_W-1:0] pulse_count [FAN_COUNT];
	logic [COUNT_W-1:0] elapsed;
	logic [SPEED_W-1:0] samples [FAN_COUNT][WINDOW_SIZE];
	int                 fill [FAN_COUNT];
	int                 wr_pos [FAN_COUNT];
	logic [SPEED_W-1:0] held_rpm [FAN_COUNT];

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	// Median of the filled entries; an even count takes the floor of the middle pair's mean.
	function automatic logic [SPEED_W-1:0] window_median(input int fan);
		logic [SPEED_W-1:0] sorted [WINDOW_SIZE];
		logic [SPEED_W-1:0] key;
		logic [SPEED_W:0]   pair_sum;
		int                 n;
		int                 j;
		n = fill[fan];
		for (int i = 0; i < n; i++)
			sorted[i] = samples[fan][i];
		for (int i = 1; i < n; i++) begin
			key = sorted[i];
			j = i;
			while (j > 0 && sorted[j-1] > key) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = key;
		end
		if (n % 2 == 1)
			return sorted[n/2];
		pair_sum = {1'b0, sorted[n/2-1]} + {1'b0, sorted[n/2]};
		return pair_sum[SPEED_W:1];
	endfunction

	// Turn one fan's pulse count into rpm; return 1 when the value is dropped as a spike.
	function automatic logic evaluate_fan(input int fan);
		longint unsigned raw;
		longint unsigned per;
		longint unsigned ppr;
		per = (period_ms == '0) ? 64'd1 : 64'(period_ms);
		ppr = (pulses_per_rev == '0) ? 64'd1 : 64'(pulses_per_rev);
		raw = 64'(pulse_count[fan]) * 64'(MS_PER_MINUTE);
		raw = raw / per / ppr;
		pulse_count[fan] = '0;
		if (raw > 64'(rpm_ceiling))
			return 1'b1;
		samples[fan][wr_pos[fan]] = raw[SPEED_W-1:0];
		wr_pos[fan] = (wr_pos[fan] == WINDOW_SIZE - 1) ? 0 : wr_pos[fan] + 1;
		if (fill[fan] < WINDOW_SIZE)
			fill[fan]++;
		held_rpm[fan] = window_median(fan);
		return 1'b0;
	endfunction

	task automatic advance_tacho(input logic e0, input logic e1, input logic tick);
		rpm_report_t        report;
		logic [COUNT_W-1:0] due;
		if (e0 && pulse_count[0] != COUNT_MAX)
			pulse_count[0]++;
		if (e1 && pulse_count[1] != COUNT_MAX)
			pulse_count[1]++;
		if (tick && elapsed != COUNT_MAX)
			elapsed++;
		due = (period_ms == '0) ? 16'd1 : period_ms;
		if (elapsed < due)
			return;
		report.spike0 = evaluate_fan(0);
		report.spike1 = evaluate_fan(1);
		elapsed = '0;
		report.speed0 = held_rpm[0];
		report.speed1 = held_rpm[1];
		reports_due.push_back(report);
	endtask

	task automatic compare_field(input string field, input logic [SPEED_W-1:0] want_v,
			input logic [SPEED_W-1:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", field, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_ms      = RST_UPDATE_PERIOD;
			pulses_per_rev = RST_PULSES_PER_REV;
			rpm_ceiling    = RST_MAX_RPM;
			elapsed        = '0;
			for (int f = 0; f < FAN_COUNT; f++) begin
				pulse_count[f] = '0;
				fill[f]        = 0;
				wr_pos[f]      = 0;
				held_rpm[f]    = '0;
			end
			reports_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_UPDATE_PERIOD:  period_ms      = cfg_data[COUNT_W-1:0];
					CFG_PULSES_PER_REV: pulses_per_rev = cfg_data[PPR_W-1:0];
					CFG_MAX_RPM:        rpm_ceiling    = cfg_data[SPEED_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				advance_tacho(edge_fan0, edge_fan1, ms_tick);
			if (out_valid && !out_stall) begin
				if (reports_due.size() == 0) begin
					$error("unexpected rpm report: speed_fan0 %0d, speed_fan1 %0d",
						speed_fan0, speed_fan1);
					mismatches++;
				end else begin
					oldest = reports_due.pop_front();
					compare_field("speed_fan0", oldest.speed0, speed_fan0);
					compare_field("speed_fan1", oldest.speed1, speed_fan1);
					compare_field("spike_fan0", SPEED_W'(oldest.spike0), SPEED_W'(spike_fan0));
					compare_field("spike_fan1", SPEED_W'(oldest.spike1), SPEED_W'(spike_fan1));
				end
			end
		end
		pending = reports_due.size();
	end

endmodule

FILE: tb/sv/tb_fan_tacho_rpm_median.sv
// Testbench top for the two-fan tachometer: stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps
module tb_fan_tacho_rpm_median;
	import ftrm_pkg::*;

	localparam int WINDOW_SIZE     = 5;
	localparam int IDLE_MAX        = 17;
	// The settle time is rounded up from the length of an update for both fans.
	localparam int SETTLE_CYCLES   = 300;
	localparam int HOLD_OFF_CYCLES = 400;
	// Longest quiet stretch: settle time, register writes, hold-off and a full update.
	localparam int STALL_LIMIT     = 4000;
	localparam int SWEEP_PHASES    = 9;
	localparam int SWEEP_BEATS     = 50;
	localparam int PRESSURE_PHASE  = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
	localparam logic [SPEED_W-1:0]   RPM_TOP      = {SPEED_W{1'b1}};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  edge_fan0 = 1'b0;
	logic                  edge_fan1 = 1'b0;
	logic                  ms_tick   = 1'b0;
	logic                  out_stall = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	logic                  in_stall;
	logic                  out_valid;
	logic [SPEED_W-1:0]    speed_fan0;
	logic [SPEED_W-1:0]    speed_fan1;
	logic                  spike_fan0;
	logic                  spike_fan1;

	int                    mismatches;
	int                    pending;

	// Idle bounds for each side, set per phase; 0 gives a stretch with no idling.
	int                    tx_idle_max  = 0;
	int                    rx_idle_max  = 0;
	bit                    hold_off_req = 1'b0;
	int                    quiet_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	fan_tacho_rpm_median #(.WINDOW_SIZE(WINDOW_SIZE)) dut (.*);

	fan_tacho_rpm_median_check #(.WINDOW_SIZE(WINDOW_SIZE)) checker_i (.*);

	// Bail out when neither channel moves a beat for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver: draw a stall before each report beat, or hold off for a long
	// stretch when asked, so the block backs up and stalls its input.
	initial begin : receiver
		int hold;
		@(posedge arst_n);
		forever begin
			hold = $urandom_range(0, rx_idle_max);
			if (hold_off_req) begin
				hold = HOLD_OFF_CYCLES;
				hold_off_req = 1'b0;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!(out_valid && !out_stall))
				@(posedge clk);
			@(negedge clk);
		end
	end

	function automatic logic chance(input int num, input int den);
		return $urandom_range(0, den - 1) < num;
	endfunction

	// Offer one beat after a drawn gap; keep valid high across back-to-back beats.
	task automatic send_beat(input logic e0, input logic e1, input logic tick);
		int gap;
		gap = $urandom_range(0, tx_idle_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		edge_fan0 <= e0;
		edge_fan1 <= e1;
		ms_tick   <= tick;
		@(posedge clk);
		while (!(in_valid && !in_stall))
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid, wait for every report due, then let the block go idle.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input logic [COUNT_W-1:0] period, input logic [PPR_W-1:0] ppr,
			input logic [SPEED_W-1:0] rpm_max);
		write_reg(CFG_UPDATE_PERIOD, CFG_DATA_W'(period));
		write_reg(CFG_PULSES_PER_REV, CFG_DATA_W'(ppr));
		write_reg(CFG_MAX_RPM, CFG_DATA_W'(rpm_max));
	endtask

	initial begin : stimulus
		logic [COUNT_W-1:0] period;
		logic [SPEED_W-1:0] rpm_max;
		int                 dens0;
		int                 dens1;
		int                 tick_dens;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset defaults: 1000 ms period, 2 pulses per rev, 10000 rpm ceiling.
		// Fan 0 edges are sparse (kept), fan 1 edges dense (spike).
		rx_idle_max = IDLE_MAX;
		for (int i = 0; i < 1000; i++)
			send_beat(chance(1, 8), chance(1, 2), 1'b1);
		settle();

		// Zero period acts as 1 ms: every tick closes a period.
		// 7 pulses per rev gives odd sums, so the even-fill median rounds down.
		tx_idle_max = IDLE_MAX;
		configure(16'd0, 4'd7, 17'd10000);
		send_beat(1'b1, 1'b1, 1'b1);
		send_beat(1'b0, 1'b1, 1'b1);
		send_beat(1'b1, 1'b1, 1'b0);
		// Fan 0 doubles up and spikes; fan 1 stays in range.
		send_beat(1'b1, 1'b0, 1'b1);
		send_beat(1'b0, 1'b0, 1'b1);
		// Fill the window and wrap over the oldest sample.
		send_beat(1'b1, 1'b1, 1'b1);
		send_beat(1'b0, 1'b0, 1'b1);
		send_beat(1'b1, 1'b0, 1'b1);
		settle();

		// Zero pulses per rev acts as 1; a zero ceiling keeps only idle fans.
		configure(16'd1, 4'd0, 17'd0);
		write_reg(CFG_UNMAPPED, '1);
		send_beat(1'b0, 1'b0, 1'b1);
		send_beat(1'b1, 1'b0, 1'b1);
		send_beat(1'b0, 1'b1, 1'b0);
		send_beat(1'b0, 1'b1, 1'b1);
		settle();

		// Edges and ticks of the same beat belong to the closing period.
		configure(16'd3, 4'd15, RPM_TOP);
		send_beat(1'b1, 1'b1, 1'b1);
		send_beat(1'b1, 1'b1, 1'b0);
		send_beat(1'b1, 1'b1, 1'b1);
		send_beat(1'b0, 1'b0, 1'b1);
		settle();

		// Long period with no idling; fan 0 gets an edge every beat and the
		// ticks start late, so edges pile up over one period.
		tx_idle_max = 0;
		rx_idle_max = 0;
		configure(16'd250, 4'd1, RPM_TOP);
		for (int i = 0; i < 50; i++)
			send_beat(1'b1, chance(1, 2), 1'b0);
		for (int i = 0; i < 250; i++)
			send_beat(1'b1, chance(1, 2), 1'b1);
		settle();

		// Random sweeps over short periods, pulse settings drawn from the full range and a spread of ceilings.
		for (int p = 0; p < SWEEP_PHASES; p++) begin
			period = COUNT_W'($urandom_range(1, 12));
			case ($urandom_range(0, 3))
				0:       rpm_max = '0;
				1:       rpm_max = RPM_TOP;
				default: rpm_max = SPEED_W'($urandom_range(0, (1 << SPEED_W) - 1));
			endcase
			dens0       = $urandom_range(0, 8);
			dens1       = $urandom_range(0, 8);
			tick_dens   = $urandom_range(1, 4);
			tx_idle_max = chance(1, 3) ? 0 : IDLE_MAX;
			rx_idle_max = chance(1, 3) ? 0 : IDLE_MAX;
			if (p == PRESSURE_PHASE) begin
				// Every beat closes a period while the receiver holds off.
				period       = 16'd1;
				tick_dens    = 4;
				tx_idle_max  = 0;
				hold_off_req = 1'b1;
			end
			configure(period, PPR_W'($urandom_range(0, 15)), rpm_max);
			for (int i = 0; i < SWEEP_BEATS; i++)
				send_beat(chance(dens0, 8), chance(dens1, 8), chance(tick_dens, 4));
			settle();
		end

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
